### rtl/core/mrf_pkg.sv
package mrf_pkg;

   localparam int FRAME_BYTES  = 8;
   localparam int HEADER_BYTES = 6;
   localparam int BYTE_IDX_W   = $clog2(FRAME_BYTES);
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [BYTE_IDX_W-1:0] LAST_IDX   = BYTE_IDX_W'(FRAME_BYTES - 1);
   localparam logic [BYTE_IDX_W-1:0] HEADER_END = BYTE_IDX_W'(HEADER_BYTES);

   typedef struct packed {
      logic [47:0] frame;
      logic [15:0] crc;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_port_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_byte(input entry_type e,
                                             input logic [BYTE_IDX_W-1:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0: b = e.frame[47:40];
         3'd1: b = e.frame[39:32];
         3'd2: b = e.frame[31:24];
         3'd3: b = e.frame[23:16];
         3'd4: b = e.frame[15:8];
         3'd5: b = e.frame[7:0];
         3'd6: b = e.crc[7:0];
         default: b = e.crc[15:8];
      endcase
      return b;
   endfunction

endpackage

### rtl/core/mrf_front.sv
module mrf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_slave_addr,
   input  logic [7:0]             req_func,
   input  logic [15:0]            req_reg_address,
   input  logic [15:0]            req_word,
   input  logic                   q_full,
   output mrf_pkg::queue_port_type q_push
);

   logic                              busy_ff, busy_in;
   logic [mrf_pkg::BYTE_IDX_W-1:0]    cnt_ff, cnt_in;
   logic [47:0]                       frame_ff, frame_in;
   logic [15:0]                       crc_ff, crc_in;
   logic                              done;
   logic                              push;
   logic                              accept;

   assign done      = busy_ff && (cnt_ff == mrf_pkg::HEADER_END);
   assign push      = done && !q_full;
   assign req_ready = !busy_ff || push;
   assign accept    = req_valid && req_ready;

   assign q_push.valid       = push;
   assign q_push.entry.frame = frame_ff;
   assign q_push.entry.crc   = crc_ff;

   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      frame_in = frame_ff;
      crc_in   = crc_ff;
      priority if (accept) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         frame_in = {req_slave_addr, req_func, req_reg_address, req_word};
         crc_in   = mrf_pkg::CRC_INIT;
      end else if (push) begin
         busy_in = 1'b0;
      end else if (busy_ff && !done) begin
         // rotate so the next header byte sits on top; six rotations restore it
         crc_in   = mrf_pkg::crc_feed(crc_ff, frame_ff[47:40]);
         frame_in = {frame_ff[39:0], frame_ff[47:40]};
         cnt_in   = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      frame_ff <= frame_in;
      crc_ff   <= crc_in;
   end

endmodule

### rtl/core/mrf_queue.sv
module mrf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  mrf_pkg::queue_port_type q_push,
   output logic                    q_full,
   output mrf_pkg::queue_port_type q_head,
   input  logic                    q_pop
);

   mrf_pkg::entry_type                mem_ff [mrf_pkg::QUEUE_DEPTH];
   logic [mrf_pkg::QUEUE_PTR_W-1:0]   wr_ff, wr_in;
   logic [mrf_pkg::QUEUE_PTR_W-1:0]   rd_ff, rd_in;
   logic [mrf_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_full       = (count_ff == mrf_pkg::QUEUE_CNT_W'(mrf_pkg::QUEUE_DEPTH));
   assign q_head.valid = (count_ff != '0);
   assign q_head.entry = mem_ff[rd_ff];
   assign do_push      = q_push.valid && !q_full;
   assign do_pop       = q_pop && q_head.valid;

   always_comb begin
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= q_push.entry;
      end
   end

endmodule

### rtl/core/mrf_back.sv
module mrf_back (
   input  logic                    clock,
   input  logic                    reset,
   input  mrf_pkg::queue_port_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_tx_byte,
   output logic                    rsp_last
);

   logic [mrf_pkg::BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                           valid_ff, valid_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           advance;

   assign advance = q_head.valid && (!valid_ff || rsp_ready);
   assign q_pop   = advance && (idx_ff == mrf_pkg::LAST_IDX);

   assign rsp_valid   = valid_ff;
   assign rsp_tx_byte = byte_ff;
   assign rsp_last    = last_ff;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      priority if (advance) begin
         valid_in = 1'b1;
         byte_in  = mrf_pkg::frame_byte(q_head.entry, idx_ff);
         last_in  = (idx_ff == mrf_pkg::LAST_IDX);
         idx_in   = idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

endmodule

### rtl/core/modbus_rtu_request_framer_core.sv
// Modbus RTU request framer.
// Request channel (req_*): one request per item - slave address, function
// code, register address and word. The function code is passed as given.
// Result channel (rsp_*): eight byte items per request in transmit order:
// address, function, register address high/low, word high/low, then the
// CRC-16/MODBUS low and high byte; rsp_last marks the CRC high byte.
// The CRC runs one header byte per cycle in the front end; a two-entry
// queue feeds the back end, which sends one byte per cycle while rsp_ready
// is high, so request throughput is set by the output byte rate, and the
// front end can take a new request while earlier frames are still sent.
// Reset (synchronous, active high) empties the front end, queue and output
// register; no item is pending afterwards.
// A stalled receiver holds rsp_* steady; the queue and front end fill and
// req_ready drops until bytes drain again.
module modbus_rtu_request_framer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_slave_addr,
   input  logic [7:0]  req_func,
   input  logic [15:0] req_reg_address,
   input  logic [15:0] req_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last
);

   mrf_pkg::queue_port_type q_push;
   mrf_pkg::queue_port_type q_head;
   logic                    q_full;
   logic                    q_pop;

   mrf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_slave_addr  (req_slave_addr),
      .req_func        (req_func),
      .req_reg_address (req_reg_address),
      .req_word        (req_word),
      .q_full          (q_full),
      .q_push          (q_push)
   );

   mrf_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   mrf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_tx_byte (rsp_tx_byte),
      .rsp_last    (rsp_last)
   );

endmodule

### rtl/core/mrf_checker.sv
module mrf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_last
);

   logic [2:0] beat_ff, beat_in;
   logic [2:0] pending_ff, pending_in;
   logic       req_take;
   logic       rsp_take;
   logic       frame_end;

   assign req_take  = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign frame_end = rsp_take && rsp_last;

   always_comb begin
      beat_in    = rsp_take ? beat_ff + 1'b1 : beat_ff;
      pending_in = pending_ff + {2'b00, req_take} - {2'b00, frame_end};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff    <= '0;
         pending_ff <= '0;
      end else begin
         beat_ff    <= beat_in;
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tx_byte) && $stable(rsp_last))
      else $error("stalled result item changed");

   a_last_on_eighth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (beat_ff == 3'd7)))
      else $error("last flag not on eighth byte");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 3'd0))
      else $error("result item without request");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (pending_ff != 3'd0))
      else $error("request refused while empty");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind modbus_rtu_request_framer_core mrf_checker u_mrf_checker (.*);

### tb/modbus_rtu_request_framer_core_tb.sv
`default_nettype none

module modbus_rtu_request_framer_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0]  FUNC_READ_HOLDING  = 8'h03;
   localparam logic [7:0]  FUNC_READ_INPUT    = 8'h04;
   localparam logic [7:0]  FUNC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0]  FUNC_UNKNOWN_ZERO  = 8'h00;
   localparam logic [7:0]  FUNC_UNKNOWN_ONES  = 8'hFF;
   localparam logic [7:0]  FUNC_UNKNOWN_ODD   = 8'hAA;
   localparam logic [7:0]  FUNC_UNKNOWN_EVEN  = 8'h55;
   localparam logic [15:0] CRC_SEED           = 16'hFFFF;
   localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
   localparam int          HEADER_LEN         = 6;
   localparam int          STALL_LIMIT        = 1000;
   localparam int          LONG_HOLD_CYCLES   = 200;
   localparam int          SETTLE_CYCLES      = 24;
   localparam int          CHUNK_ITEMS        = 40;
   localparam int          RANDOM_CHUNKS      = 8;
   localparam int          PRESSURE_ITEMS     = 30;
   localparam int          CALM_ITEMS         = 50;
   localparam int          REPORT_LIMIT       = 10;

   typedef struct packed {
      logic [7:0]  slave_addr;
      logic [7:0]  func;
      logic [15:0] reg_address;
      logic [15:0] word;
   } modbus_request_type;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
   } frame_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_slave_addr = '0;
   logic [7:0]  req_func = '0;
   logic [15:0] req_reg_address = '0;
   logic [15:0] req_word = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;

   modbus_request_type pending_requests[$];
   frame_byte_type     expected_bytes[$];
   frame_byte_type     oldest_byte;

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int tx_gap = 0;
   int rx_gap = 0;
   int hold_left = 0;
   int holds_asked = 0;
   int holds_done = 0;
   bit req_taken = 1'b0;
   bit failed = 1'b0;
   int requests_taken = 0;
   int bytes_checked = 0;
   int mismatches = 0;
   int stall_cycles = 0;
   int directed_count = 0;

   modbus_rtu_request_framer_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_slave_addr  (req_slave_addr),
      .req_func        (req_func),
      .req_reg_address (req_reg_address),
      .req_word        (req_word),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [15:0] modbus_crc16(input logic [47:0] header);
      logic [15:0] crc;
      crc = CRC_SEED;
      for (int k = HEADER_LEN - 1; k >= 0; k--) begin
         crc = crc ^ {8'h00, header[k*8 +: 8]};
         for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
               crc = (crc >> 1) ^ CRC_REFLECTED_POLY;
            end else begin
               crc = crc >> 1;
            end
         end
      end
      return crc;
   endfunction

   task automatic predict_frame(input modbus_request_type r);
      logic [47:0] header;
      logic [15:0] crc;
      header = {r.slave_addr, r.func, r.reg_address, r.word};
      crc = modbus_crc16(header);
      for (int k = HEADER_LEN - 1; k >= 0; k--) begin
         expected_bytes.push_back('{tx_byte: header[k*8 +: 8], last: 1'b0});
      end
      expected_bytes.push_back('{tx_byte: crc[7:0], last: 1'b0});
      expected_bytes.push_back('{tx_byte: crc[15:8], last: 1'b1});
   endtask

   function automatic modbus_request_type make_request(input logic [7:0] slave_addr,
                                                       input logic [7:0] func,
                                                       input logic [15:0] reg_address,
                                                       input logic [15:0] word);
      modbus_request_type r;
      r.slave_addr = slave_addr;
      r.func = func;
      r.reg_address = reg_address;
      r.word = word;
      return r;
   endfunction

   function automatic modbus_request_type random_request();
      modbus_request_type r;
      r.slave_addr = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         0, 1, 2: r.func = FUNC_READ_HOLDING;
         3, 4:    r.func = FUNC_READ_INPUT;
         5, 6:    r.func = FUNC_WRITE_SINGLE;
         default: r.func = 8'($urandom_range(0, 255));
      endcase
      r.reg_address = 16'($urandom_range(0, 65535));
      if (r.func != FUNC_WRITE_SINGLE && $urandom_range(0, 2) == 0) begin
         r.word = 16'($urandom_range(1, 125));
      end else begin
         r.word = 16'($urandom_range(0, 65535));
      end
      return r;
   endfunction

   // drain: also wait for every expected byte; return just after a rising edge
   task automatic wait_for_queue(input bit drain);
      while (pending_requests.size() != 0 || (drain && (req_valid ||
             expected_bytes.size() != 0))) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) begin
         pending_requests.push_back(random_request());
      end
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold
      end else if (tx_gap > 0) begin
         req_valid <= 1'b0;
         tx_gap <= tx_gap - 1;
      end else if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         tx_gap <= $urandom_range(0, 12);
      end else if (pending_requests.size() != 0) begin
         {req_slave_addr, req_func, req_reg_address, req_word} <= pending_requests.pop_front();
         req_valid <= 1'b1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // receiver
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done <= holds_done + 1;
         hold_left <= LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_ready <= 1'b0;
      end else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct) begin
         rx_gap <= $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            requests_taken++;
            predict_frame({req_slave_addr, req_func, req_reg_address, req_word});
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               failed = 1'b1;
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("unexpected byte %h last %b at %t", rsp_tx_byte, rsp_last, $realtime);
               end
            end else begin
               oldest_byte = expected_bytes.pop_front();
               bytes_checked++;
               if (rsp_tx_byte !== oldest_byte.tx_byte || rsp_last !== oldest_byte.last) begin
                  failed = 1'b1;
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("byte %0d: expected tx_byte %h last %b, got tx_byte %h last %b",
                              bytes_checked - 1, oldest_byte.tx_byte, oldest_byte.last,
                              rsp_tx_byte, rsp_last);
                  end
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("no handshake for %0d cycles, %0d bytes still expected",
                     STALL_LIMIT, expected_bytes.size());
            $display("modbus_rtu_request_framer_core_tb failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      modbus_request_type directed[$];
      directed = {
         make_request(8'h00, FUNC_UNKNOWN_ZERO, 16'h0000, 16'h0000),
         make_request(8'hFF, FUNC_UNKNOWN_ONES, 16'hFFFF, 16'hFFFF),
         make_request(8'h01, FUNC_READ_HOLDING, 16'h0000, 16'h000A),
         make_request(8'h11, FUNC_READ_INPUT, 16'h0008, 16'h0001),
         make_request(8'h7F, FUNC_WRITE_SINGLE, 16'h0001, 16'h0003),
         make_request(8'h80, FUNC_WRITE_SINGLE, 16'h8000, 16'hFFFF),
         make_request(8'h01, FUNC_UNKNOWN_ZERO, 16'hFFFF, 16'h0000),
         make_request(8'hF7, FUNC_UNKNOWN_ONES, 16'h00FF, 16'hFF00),
         make_request(8'h55, FUNC_UNKNOWN_ODD, 16'hAA55, 16'h55AA),
         make_request(8'hAA, FUNC_UNKNOWN_EVEN, 16'h55AA, 16'hAA55),
         make_request(8'h00, FUNC_READ_HOLDING, 16'hFF00, 16'h00FF),
         make_request(8'hFF, FUNC_WRITE_SINGLE, 16'h1234, 16'hABCD)
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 20;
      rx_idle_pct = 20;
      foreach (directed[i]) begin
         pending_requests.push_back(directed[i]);
      end
      directed_count = directed.size();
      // wait until the directed frames are out before the random chunks
      wait_for_queue(1'b1);

      for (int c = 0; c < RANDOM_CHUNKS; c++) begin
         case ($urandom_range(0, 3))
            0: tx_idle_pct = 0;
            1: tx_idle_pct = 8;
            2: tx_idle_pct = 25;
            default: tx_idle_pct = 50;
         endcase
         case ($urandom_range(0, 3))
            0: rx_idle_pct = 0;
            1: rx_idle_pct = 8;
            2: rx_idle_pct = 25;
            default: rx_idle_pct = 50;
         endcase
         push_random(CHUNK_ITEMS);
         wait_for_queue(1'b0);
      end

      // long output hold while the sender keeps offering
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      holds_asked = holds_asked + 1;
      push_random(PRESSURE_ITEMS);
      wait_for_queue(1'b1);

      push_random(CALM_ITEMS);
      wait_for_queue(1'b1);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_bytes.size() != 0) begin
         failed = 1'b1;
         $display("%0d expected bytes never arrived", expected_bytes.size());
      end
      $display("covered %0d requests (%0d directed, rest random with stalls on both sides",
               requests_taken, directed_count);
      $display("and a %0d-cycle output hold), %0d frame bytes checked, %0d mismatches",
               LONG_HOLD_CYCLES, bytes_checked, mismatches);
      if (!failed) begin
         $display("modbus_rtu_request_framer_core_tb passed");
      end else begin
         $display("modbus_rtu_request_framer_core_tb failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
